FILE: rtl/rehit_pkg.sv
// ----------------------------------------------------------------------------
// rehit_pkg
// Shared constants and types for the ray edge farthest hit block.
// ----------------------------------------------------------------------------
package rehit_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int DIR_BITS       = 16;
  localparam int P_BITS         = DIR_BITS + 2;   // probe extent, dir * 4
  localparam int QDEPTH         = 2;
  localparam int DIST_BITS      = 52;
  localparam int CFG_IDX_BITS   = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Z = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_X    = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_DIR_Z    = CFG_IDX_BITS'(3);

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/rehit_ifs.sv
// ----------------------------------------------------------------------------
// rehit channel interfaces
// Valid/ready channels for incoming edges and outgoing hit results.
// ----------------------------------------------------------------------------
interface rehit_edge_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] edge_ax;
  logic signed [COORD_BITS-1:0] edge_az;
  logic signed [COORD_BITS-1:0] edge_bx;
  logic signed [COORD_BITS-1:0] edge_bz;
  logic                         last_edge;
  modport source (output valid, edge_ax, edge_az, edge_bx, edge_bz, last_edge, input ready);
  modport sink   (input valid, edge_ax, edge_az, edge_bx, edge_bz, last_edge, output ready);
endinterface

interface rehit_hit_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic                         hit_found;
  logic signed [COORD_BITS-1:0] hit_x;
  logic signed [COORD_BITS-1:0] hit_z;
  modport source (output valid, hit_found, hit_x, hit_z, input ready);
  modport sink   (input valid, hit_found, hit_x, hit_z, output ready);
endinterface

FILE: rtl/ray_edge_farthest_hit_core.sv
// ----------------------------------------------------------------------------
// ray_edge_farthest_hit_core
// Farthest crossing of a probe segment (origin + dir * 4) with a stream
// of edges; one result per query, on the last edge.
// ----------------------------------------------------------------------------
//   channel   dir  beat contents
//   edge_in   in   edge_ax, edge_az, edge_bx, edge_bz, last_edge
//   hit_out   out  hit_found, hit_x, hit_z
//   cfg       in   cfg_we, cfg_index, cfg_data (origin_x, origin_z, dir_x, dir_z)
//
// A rejected edge takes only the evaluation sequencer's issue slot; an
// accepted candidate passes through issue, 18 divide steps of the serial
// divider, square and update; the last edge also loads the result register.
// The front stage and the two-entry queue keep taking edges while the
// divider runs. Reset is synchronous and clears query state and config registers.
// A stalled result holds the sequencer only at the emit step.
// ----------------------------------------------------------------------------
module ray_edge_farthest_hit_core #(
  parameter int COORD_BITS = rehit_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  rehit_edge_if.sink                               edge_in,
  rehit_hit_if.source                              hit_out,
  input  logic                                     cfg_we,
  input  logic [rehit_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [((COORD_BITS > rehit_pkg::DIR_BITS) ? COORD_BITS
                 : rehit_pkg::DIR_BITS)-1:0]       cfg_data
);
  import rehit_pkg::*;

  localparam int DW = 2 * COORD_BITS + 3;
  localparam int EW = 2 * DW + 2;

  logic signed [COORD_BITS-1:0] origin_x, origin_z;
  logic signed [DIR_BITS-1:0]   dir_x, dir_z;
  q_status_t                    qs;
  logic                         q_push, q_pop;
  logic [EW-1:0]                q_wdata, q_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_z <= '0;
      dir_x    <= '0;
      dir_z    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data[COORD_BITS-1:0];
        REG_ORIGIN_Z: origin_z <= cfg_data[COORD_BITS-1:0];
        REG_DIR_X:    dir_x    <= cfg_data[DIR_BITS-1:0];
        REG_DIR_Z:    dir_z    <= cfg_data[DIR_BITS-1:0];
        default: ;
      endcase
    end
  end

  rehit_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst, .edge_in, .origin_x, .origin_z, .dir_x, .dir_z,
    .qs, .push(q_push), .push_data(q_wdata)
  );

  rehit_queue #(.WIDTH(EW)) u_queue (
    .clk, .rst, .push(q_push), .push_data(q_wdata), .pop(q_pop),
    .pop_data(q_rdata), .qs
  );

  rehit_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk, .rst, .qs, .pop_data(q_rdata), .pop(q_pop),
    .origin_x, .origin_z, .dir_x, .dir_z, .hit_out
  );

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && qs.full)) else $error("queue pushed while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && qs.empty)) else $error("queue popped while empty");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (hit_out.valid && !hit_out.hit_found) |-> (hit_out.hit_x == '0 && hit_out.hit_z == '0))
    else $error("miss result carries a nonzero point");
`endif

endmodule

FILE: rtl/rehit_front.sv
// ----------------------------------------------------------------------------
// rehit_front
// Accepts edges, forms the cross-product numerators and denominator,
// classifies the edge as a candidate hit and pushes it into the queue.
// ----------------------------------------------------------------------------
module rehit_front #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  rehit_edge_if.sink                    edge_in,
  input  logic signed [COORD_BITS-1:0]  origin_x,
  input  logic signed [COORD_BITS-1:0]  origin_z,
  input  logic signed [rehit_pkg::DIR_BITS-1:0] dir_x,
  input  logic signed [rehit_pkg::DIR_BITS-1:0] dir_z,
  input  rehit_pkg::q_status_t          qs,
  output logic                          push,
  output logic [2*(2*COORD_BITS+3)+1:0] push_data
);
  import rehit_pkg::*;

  localparam int VW = COORD_BITS + 1;
  localparam int DW = 2 * COORD_BITS + 3;
  localparam int XW = (DW > 65) ? DW : 65;
  localparam logic signed [XW-1:0] LIM = XW'(64'sd1 <<< 62);

  logic                 sv;
  logic                 s_last;
  logic signed [VW-1:0] ex, ez, wx, wz;

  logic signed [P_BITS-1:0]      px, pz;
  logic signed [VW+P_BITS-1:0]   mu1, mu2;
  logic signed [2*VW-1:0]        mt1, mt2;
  logic signed [VW+P_BITS-1:0]   ms1, ms2;
  logic signed [DW-1:0]          under, num_t, num_s;
  logic signed [XW-1:0]          xu, xt, xs;
  logic [DW-1:0]                 mag_u, mag_t, mag_s;
  logic                          bad, t_ok, s_ok, ok;

  assign edge_in.ready = !sv || !qs.full;
  assign push          = sv && !qs.full;

  // hold one edge as differences against its first endpoint
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= 1'b0;
    end else if (edge_in.ready) begin
      sv <= edge_in.valid;
    end
    if (edge_in.valid && edge_in.ready) begin
      ex     <= VW'(edge_in.edge_bx) - VW'(edge_in.edge_ax);
      ez     <= VW'(edge_in.edge_bz) - VW'(edge_in.edge_az);
      wx     <= VW'(origin_x) - VW'(edge_in.edge_ax);
      wz     <= VW'(origin_z) - VW'(edge_in.edge_az);
      s_last <= edge_in.last_edge;
    end
  end

  // cross products
  always_comb begin
    px    = {dir_x, 2'b00};
    pz    = {dir_z, 2'b00};
    mu1   = ez * px;
    mu2   = ex * pz;
    mt1   = ex * wz;
    mt2   = ez * wx;
    ms1   = px * wz;
    ms2   = pz * wx;
    under = DW'(mu1) - DW'(mu2);
    num_t = DW'(mt1) - DW'(mt2);
    num_s = DW'(ms1) - DW'(ms2);
  end

  // classify: overrange, parallel, outside 0..1, both numerators zero
  always_comb begin
    xu    = XW'(under);
    xt    = XW'(num_t);
    xs    = XW'(num_s);
    bad   = (xu > LIM) || (xu < -LIM) || (xt > LIM) || (xt < -LIM) ||
            (xs > LIM) || (xs < -LIM);
    mag_u = under[DW-1] ? DW'(-under) : DW'(under);
    mag_t = num_t[DW-1] ? DW'(-num_t) : DW'(num_t);
    mag_s = num_s[DW-1] ? DW'(-num_s) : DW'(num_s);
    t_ok  = (num_t == '0) || ((num_t[DW-1] == under[DW-1]) && (mag_t <= mag_u));
    s_ok  = (num_s == '0) || ((num_s[DW-1] == under[DW-1]) && (mag_s <= mag_u));
    ok    = !bad && (under != '0) && t_ok && s_ok && !((num_t == '0) && (num_s == '0));
  end

  assign push_data = {ok, s_last, num_t, under};

endmodule

FILE: rtl/rehit_queue.sv
// ----------------------------------------------------------------------------
// rehit_queue
// Short queue that decouples edge classification from hit evaluation.
// ----------------------------------------------------------------------------
module rehit_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output rehit_pkg::q_status_t qs
);
  import rehit_pkg::*;

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] mem [QDEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign qs.full   = (count == CW'(QDEPTH));
  assign qs.empty  = (count == '0);
  assign pop_data  = mem[rd_ptr];

  // store beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/rehit_back.sv
// ----------------------------------------------------------------------------
// rehit_back
// Evaluates queued candidates: serial scaled division for the hit offset,
// squared distance, farthest-hit update and result emission.
// ----------------------------------------------------------------------------
module rehit_back #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rehit_pkg::q_status_t          qs,
  input  logic [2*(2*COORD_BITS+3)+1:0] pop_data,
  output logic                          pop,
  input  logic signed [COORD_BITS-1:0]  origin_x,
  input  logic signed [COORD_BITS-1:0]  origin_z,
  input  logic signed [rehit_pkg::DIR_BITS-1:0] dir_x,
  input  logic signed [rehit_pkg::DIR_BITS-1:0] dir_z,
  rehit_hit_if.source                   hit_out
);
  import rehit_pkg::*;

  localparam int DW  = 2 * COORD_BITS + 3;
  localparam int RW  = DW + 1;
  localparam int OW  = P_BITS + 1;
  localparam int SQW = 2 * P_BITS;
  localparam int SW  = ((COORD_BITS > OW) ? COORD_BITS : OW) + 1;
  localparam int CNTW = $clog2(P_BITS);
  localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] CMIN = SW'(-(64'sd1 <<< (COORD_BITS - 1)));

  typedef enum logic [2:0] {IDLE, DIV, SQR, UPD, EMIT} state_t;
  state_t state;

  logic                 e_ok, e_last;
  logic signed [DW-1:0] e_num, e_under;

  logic                     last;
  logic [DW-1:0]            n_mag, d_mag;
  logic [CNTW-1:0]          cnt;
  logic [RW-1:0]            rx, rz;
  logic [P_BITS-1:0]        qx, qz;
  logic [P_BITS-1:0]        pmx, pmz;
  logic signed [P_BITS-1:0] px, pz;
  logic                     neg_nd;
  logic [SQW-1:0]           sqx, sqz;
  logic signed [COORD_BITS-1:0] hx, hz;
  logic [DIST_BITS-1:0]     best_distance;
  logic signed [COORD_BITS-1:0] best_x, best_z;
  logic                     any_hit;
  logic                     ov;

  logic [RW+P_BITS-1:0]     stx, stz;
  logic signed [OW-1:0]     offx, offz;
  logic signed [SW-1:0]     sumx, sumz;
  logic [SQW:0]             sq_sum;

  // one step of the scaled divide: shift, reduce, add numerator on set bit
  function automatic logic [RW+P_BITS-1:0] div_step(
    input logic [RW-1:0] r, input logic [P_BITS-1:0] q, input logic b,
    input logic [DW-1:0] n, input logic [DW-1:0] d);
    logic [RW-1:0] r1, r2;
    logic          c1, c2;
    r1 = {r[RW-2:0], 1'b0};
    c1 = (r1 >= RW'(d));
    if (c1) r1 = r1 - RW'(d);
    r2 = b ? r1 + RW'(n) : r1;
    c2 = (r2 >= RW'(d));
    if (c2) r2 = r2 - RW'(d);
    return {r2, P_BITS'({q[P_BITS-2:0], 1'b0} + P_BITS'(c1) + P_BITS'(c2))};
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SW-1:0] v);
    if (v > CMAX) return COORD_BITS'(CMAX);
    if (v < CMIN) return COORD_BITS'(CMIN);
    return COORD_BITS'(v);
  endfunction

  assign {e_ok, e_last, e_num, e_under} = pop_data;
  assign pop = (state == IDLE) && !qs.empty;

  always_comb begin
    px     = {dir_x, 2'b00};
    pz     = {dir_z, 2'b00};
    stx    = div_step(rx, qx, pmx[cnt], n_mag, d_mag);
    stz    = div_step(rz, qz, pmz[cnt], n_mag, d_mag);
    offx   = (neg_nd ^ px[P_BITS-1]) ? -OW'(qx) : OW'(qx);
    offz   = (neg_nd ^ pz[P_BITS-1]) ? -OW'(qz) : OW'(qz);
    sumx   = SW'(origin_x) + SW'(offx);
    sumz   = SW'(origin_z) + SW'(offz);
    sq_sum = (SQW + 1)'(sqx) + (SQW + 1)'(sqz);
  end

  assign hit_out.valid = ov;

  // sequencer: hold state, datapath and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      ov            <= 1'b0;
      best_distance <= '0;
      best_x        <= '0;
      best_z        <= '0;
      any_hit       <= 1'b0;
    end else begin
      // raise valid on a new result, drop it once the beat is taken
      if ((state == EMIT) && (!ov || hit_out.ready)) begin
        ov <= 1'b1;
      end else if (hit_out.ready) begin
        ov <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (!qs.empty) begin
            last   <= e_last;
            n_mag  <= e_num[DW-1] ? DW'(-e_num) : DW'(e_num);
            d_mag  <= e_under[DW-1] ? DW'(-e_under) : DW'(e_under);
            neg_nd <= e_num[DW-1] ^ e_under[DW-1];
            pmx    <= px[P_BITS-1] ? P_BITS'(-px) : P_BITS'(px);
            pmz    <= pz[P_BITS-1] ? P_BITS'(-pz) : P_BITS'(pz);
            rx     <= '0;
            rz     <= '0;
            qx     <= '0;
            qz     <= '0;
            cnt    <= CNTW'(P_BITS - 1);
            if (e_ok) begin
              state <= DIV;
            end else if (e_last) begin
              state <= EMIT;
            end
          end
        end
        DIV: begin
          {rx, qx} <= stx;
          {rz, qz} <= stz;
          cnt      <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= SQR;
          end
        end
        SQR: begin
          sqx   <= qx * qx;
          sqz   <= qz * qz;
          hx    <= sat(sumx);
          hz    <= sat(sumz);
          state <= UPD;
        end
        UPD: begin
          if (best_distance < DIST_BITS'(sq_sum)) begin
            best_distance <= DIST_BITS'(sq_sum);
            best_x        <= hx;
            best_z        <= hz;
            any_hit       <= 1'b1;
          end
          state <= last ? EMIT : IDLE;
        end
        EMIT: begin
          if (!ov || hit_out.ready) begin
            hit_out.hit_found <= any_hit;
            hit_out.hit_x     <= best_x;
            hit_out.hit_z     <= best_z;
            best_distance     <= '0;
            best_x            <= '0;
            best_z            <= '0;
            any_hit           <= 1'b0;
            state             <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: dv/ray_edge_farthest_hit_core_tb.sv
// ----------------------------------------------------------------------------
// ray_edge_farthest_hit_core_tb
// Drives random and directed edge queries into the farthest hit block under
// directed and random ray settings, predicts each query result and checks every hit beat.
// ----------------------------------------------------------------------------
module ray_edge_farthest_hit_core_tb;
  import rehit_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int CW = (CB > DIR_BITS) ? CB : DIR_BITS;
  localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CB - 1));
  localparam longint LIMIT = 3000000;

  typedef struct {
    logic signed [CB-1:0] ax, az, bx, bz;
    logic                 last;
  } edge_beat_t;

  typedef struct {
    logic                 found;
    logic signed [CB-1:0] x, z;
  } hit_beat_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_data = '0;

  rehit_edge_if #(CB) edge_ch ();
  rehit_hit_if #(CB) hit_ch ();

  ray_edge_farthest_hit_core #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst), .edge_in(edge_ch.sink), .hit_out(hit_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  edge_beat_t pending_edges[$];
  hit_beat_t  expected_hits[$];
  int         errors = 0;
  longint     cycle = 0;
  int         hold_off = 0;   // long receiver stall, counted in cycles
  bit         sender_pause = 0;

  // ray settings and query state of the predictor
  longint org_x = 0, org_z = 0, dx = 0, dz = 0;
  longint best_d = 0, best_hx = 0, best_hz = 0;
  bit     any_hit = 0;

  function automatic longint absv(longint a);
    return a < 0 ? -a : a;
  endfunction

  function automatic bit in_unit(longint num, longint den);
    if (num == 0) return 1;
    if ((num < 0) != (den < 0)) return 0;
    return absv(num) <= absv(den);
  endfunction

  // (num * p) / den truncated toward zero, exact in wide arithmetic
  function automatic longint scale_off(longint num, longint den, longint p);
    logic signed [127:0] prod;
    prod = 128'(num) * 128'(p);
    return longint'(prod / 128'(den));
  endfunction

  function automatic longint sat(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  // Fold one edge into the query; on the last edge, queue the result.
  task automatic predict_hit(edge_beat_t e);
    longint px, pz, ex, ez, wx, wz, under, num_t, num_s, ox, oz, d;
    hit_beat_t h;
    px = dx * 4;
    pz = dz * 4;
    ex = longint'(e.bx) - longint'(e.ax);
    ez = longint'(e.bz) - longint'(e.az);
    wx = org_x - longint'(e.ax);
    wz = org_z - longint'(e.az);
    under = ez * px - ex * pz;
    num_t = ex * wz - ez * wx;
    num_s = px * wz - pz * wx;
    if (under != 0 && in_unit(num_t, under) && in_unit(num_s, under) &&
        !(num_t == 0 && num_s == 0)) begin
      ox = scale_off(num_t, under, px);
      oz = scale_off(num_t, under, pz);
      d = (ox * ox + oz * oz) & ((64'sd1 <<< 52) - 1);
      if (best_d < d) begin
        best_d = d;
        best_hx = sat(org_x + ox);
        best_hz = sat(org_z + oz);
        any_hit = 1;
      end
    end
    if (e.last) begin
      h.found = any_hit;
      h.x = best_hx[CB-1:0];
      h.z = best_hz[CB-1:0];
      expected_hits.push_back(h);
      best_d = 0;
      best_hx = 0;
      best_hz = 0;
      any_hit = 0;
    end
  endtask

  // Driver: offer the head of the queue, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      edge_ch.valid <= 0;
    end else begin
      if (edge_ch.valid && edge_ch.ready) begin
        predict_hit('{edge_ch.edge_ax, edge_ch.edge_az, edge_ch.edge_bx,
                      edge_ch.edge_bz, edge_ch.last_edge});
        void'(pending_edges.pop_front());
      end
      if (!(edge_ch.valid && !edge_ch.ready)) begin
        if (pending_edges.size() > 0 && !sender_pause &&
            ($urandom_range(0, 3) != 0 || cycle % 3000 < 500)) begin
          edge_ch.valid <= 1;
          edge_ch.edge_ax <= pending_edges[0].ax;
          edge_ch.edge_az <= pending_edges[0].az;
          edge_ch.edge_bx <= pending_edges[0].bx;
          edge_ch.edge_bz <= pending_edges[0].bz;
          edge_ch.last_edge <= pending_edges[0].last;
        end else begin
          edge_ch.valid <= 0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each hit beat with the oldest one.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (rst) begin
      hit_ch.ready <= 0;
    end else begin
      if (hit_ch.valid && hit_ch.ready) begin
        if (expected_hits.size() == 0) begin
          $display("%0t: unexpected hit beat %0d %0d %0d", $time,
                   hit_ch.hit_found, hit_ch.hit_x, hit_ch.hit_z);
          errors++;
        end else begin
          if (hit_ch.hit_found !== expected_hits[0].found ||
              hit_ch.hit_x !== expected_hits[0].x ||
              hit_ch.hit_z !== expected_hits[0].z) begin
            $display("%0t: expected %0d %0d %0d actual %0d %0d %0d", $time,
                     expected_hits[0].found, expected_hits[0].x, expected_hits[0].z,
                     hit_ch.hit_found, hit_ch.hit_x, hit_ch.hit_z);
            errors++;
          end
          void'(expected_hits.pop_front());
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        hit_ch.ready <= 0;
      end else if ($urandom_range(0, 99) < 2) begin
        hold_off <= $urandom_range(20, 120);
        hit_ch.ready <= 0;
      end else begin
        hit_ch.ready <= (cycle % 2000 < 400) || ($urandom_range(0, 3) != 0);
      end
    end
  end

  function automatic logic signed [CB-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return CB'(CMAX);
      1: return CB'(CMIN);
      2: return CB'($urandom);
      default: return CB'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  function automatic edge_beat_t mk_edge(longint ax, longint az, longint bx,
                                         longint bz, bit last);
    edge_beat_t e;
    e.ax = ax[CB-1:0];
    e.az = az[CB-1:0];
    e.bx = bx[CB-1:0];
    e.bz = bz[CB-1:0];
    e.last = last;
    return e;
  endfunction

  // Edge crossing the probe: random point along it, edge spans it sideways.
  function automatic edge_beat_t crossing_edge(bit last);
    longint t, cx, cz, sx, sz;
    t = $urandom_range(0, 256);
    cx = org_x + (dx * 4 * t) / 256;
    cz = org_z + (dz * 4 * t) / 256;
    sx = $signed($urandom_range(0, 4000)) - 2000;
    sz = $signed($urandom_range(0, 4000)) - 2000;
    return mk_edge(cx + sx, cz + sz, cx - sx - $urandom_range(0, 3),
                   cz - sz + $urandom_range(0, 3), last);
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[CW-1:0];
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic set_ray(longint ox, longint oz, longint rx, longint rz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, rx);
    write_reg(REG_DIR_Z, rz);
    write_reg(CFG_IDX_BITS'(7), 0);   // unmapped index, dropped
    org_x = ox;
    org_z = oz;
    dx = rx;
    dz = rz;
  endtask

  // Hold until the block has drained, then let the divider settle.
  task automatic drain();
    while (pending_edges.size() > 0 || expected_hits.size() > 0 || edge_ch.valid)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    int n;
    edge_ch.valid = 0;
    edge_ch.edge_ax = 0;
    edge_ch.edge_az = 0;
    edge_ch.edge_bx = 0;
    edge_ch.edge_bz = 0;
    edge_ch.last_edge = 0;
    hit_ch.ready = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    // directed: zero direction, parallel, hit at origin, endpoints, saturation
    set_ray(0, 0, 16384, 0);
    pending_edges.push_back(mk_edge(100, -50, 100, 50, 0));
    pending_edges.push_back(mk_edge(65536, -1, 65536, 1, 0));      // t = 1
    pending_edges.push_back(mk_edge(0, -1, 0, 1, 0));              // at origin
    pending_edges.push_back(mk_edge(10, 5, 500, 5, 0));            // parallel
    pending_edges.push_back(mk_edge(70000, -5, 70000, 5, 0));      // beyond
    pending_edges.push_back(mk_edge(5, 5, 5, 5, 1));               // degenerate
    pending_edges.push_back(mk_edge(0, 0, 0, 0, 1));               // empty query
    drain();
    set_ray(CMAX, CMIN, 16384, -16384);
    pending_edges.push_back(mk_edge(CMAX - 10, CMAX, CMAX + 10, CMIN, 0));
    pending_edges.push_back(mk_edge(CMIN, CMIN, CMAX, CMAX, 1));
    drain();
    set_ray(CMIN, CMAX, -16384, 16384);
    pending_edges.push_back(mk_edge(CMIN, CMAX, CMIN, CMAX, 0));
    pending_edges.push_back(mk_edge(CMAX, CMIN, CMIN, CMAX, 1));
    drain();
    set_ray(0, 0, 0, 0);
    pending_edges.push_back(mk_edge(-100, -100, 100, 100, 1));
    drain();
    set_ray(1000, -1000, -32768, 32767);   // beyond unit direction
    pending_edges.push_back(crossing_edge(0));
    pending_edges.push_back(crossing_edge(1));
    drain();

    // random phases
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: set_ray(rnd_coord(), rnd_coord(), $signed($urandom_range(0, 32768)) - 16384,
                   $signed($urandom_range(0, 32768)) - 16384);
        1: set_ray($signed($urandom_range(0, 20000)) - 10000,
                   $signed($urandom_range(0, 20000)) - 10000,
                   $urandom_range(0, 1) ? 16384 : -16384, $signed($urandom) >>> 16);
        2: set_ray($signed(CB'($urandom)), $signed(CB'($urandom)),
                   $signed(16'($urandom)), $signed(16'($urandom)));
        default: set_ray(0, 0, $signed($urandom_range(0, 2000)) - 1000,
                         $signed($urandom_range(0, 2000)) - 1000);
      endcase
      n = 120;
      for (int i = 0; i < n; i++) begin
        bit last;
        last = (i == n - 1) || ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) < 7)
          pending_edges.push_back(crossing_edge(last));
        else
          pending_edges.push_back(mk_edge(rnd_coord(), rnd_coord(), rnd_coord(),
                                          rnd_coord(), last));
      end
      if (ph == 5) begin
        // sender pause until every result is in
        while (pending_edges.size() > 0 || edge_ch.valid) @(posedge clk);
        sender_pause = 1;
        while (expected_hits.size() > 0) @(posedge clk);
        sender_pause = 0;
      end
      drain();
    end

    if (errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

FILE: sim.f
rtl/rehit_pkg.sv
rtl/rehit_ifs.sv
rtl/rehit_front.sv
rtl/rehit_queue.sv
rtl/rehit_back.sv
rtl/ray_edge_farthest_hit_core.sv
dv/ray_edge_farthest_hit_core_tb.sv
